>>> rtl/operand_stack_engine_macros.svh
// assertion macros shared by the operand stack engine rtl
// no dependencies; taken in by `include where assertions are written
`ifndef OPERAND_STACK_ENGINE_MACROS_SVH
`define OPERAND_STACK_ENGINE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define OSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define OSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ose_pkg.sv
// operand stack engine package: sizes, operation and status codes,
// controller/datapath command and status structs; no dependencies
package ose_pkg;

  // storage sizing
  localparam int STACK_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;

  // fixed port field widths
  localparam int OP_W    = 3;
  localparam int FIELD_W = 32;
  localparam int AMT_W   = 9;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 9;

  // derived widths
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CMP_W  = (CNT_W > AMT_W) ? CNT_W : AMT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_PEEK       = 3'd2,
    OP_REPL_TOP   = 3'd3,
    OP_REPL_AT    = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_SWAP       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // memory address sources
  typedef enum logic [2:0] {
    ADDR_TOP,
    ADDR_DEPTH,
    ADDR_PUSH,
    ADDR_REPL,
    ADDR_LO,
    ADDR_HI
  } addr_sel_t;

  // memory write data sources
  typedef enum logic [1:0] {
    WDATA_VALUE,
    WDATA_RDATA,
    WDATA_TMP
  } wdata_sel_t;

  // entry count updates
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_PUSH,
    CNT_REPL,
    CNT_POP,
    CNT_CLEAR
  } cnt_op_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wdata_sel;
    cnt_op_t    cnt_op;
    logic       rev_init;
    logic       rev_step;
    logic       tmp_load;
    logic       res_load;
    logic       res_rdata;
  } ose_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic err;
    logic rev_trivial;
    logic rev_more;
  } ose_stat_t;

endpackage

>>> rtl/ose_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ose_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/ose_datapath.sv
// operand stack engine datapath: operand capture, range checks, entry count,
// stack memory, reverse pointers and result registers; uses ose_pkg, ose_ram
module ose_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ose_pkg::OP_W-1:0]  in_operation,
  input  logic [ose_pkg::FIELD_W-1:0] in_value,
  input  logic [ose_pkg::AMT_W-1:0] in_amount,
  input  ose_pkg::ose_cmd_t         cmd,
  output ose_pkg::ose_stat_t        stat,
  output logic                      out_valid,
  output logic [ose_pkg::FIELD_W-1:0] out_read_value,
  output logic [ose_pkg::STAT_W-1:0] out_status,
  output logic [ose_pkg::DEPTH_W-1:0] out_depth
);

  import ose_pkg::*;

  op_t                    op_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [AMT_W-1:0]       amount_r;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [ADDR_W-1:0]      lo_r;
  logic [ADDR_W-1:0]      hi_r;
  logic [VALUE_WIDTH-1:0] tmp_r;
  logic [FIELD_W-1:0]     res_value_r;
  status_t                res_status_r;
  logic [DEPTH_W-1:0]     res_depth_r;
  logic                   res_valid_r;

  logic [CMP_W-1:0]       cnt_x;
  logic [CMP_W-1:0]       amt_x;
  logic [CMP_W-1:0]       rev_n;
  logic                   full;
  logic                   amt_ge;
  logic                   amt_gt;
  status_t                status;

  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] rd_data;

  // operand capture on an accepted command
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(in_operation);
      value_r  <= VALUE_WIDTH'(in_value);
      amount_r <= in_amount;
    end
  end

  // comparisons at a common width
  assign cnt_x  = CMP_W'(count_r);
  assign amt_x  = CMP_W'(amount_r);
  assign full   = cnt_x >= CMP_W'(STACK_DEPTH);
  assign amt_ge = amt_x >= cnt_x;
  assign amt_gt = amt_x > cnt_x;
  assign rev_n  = (op_r == OP_SWAP) ? CMP_W'(2) : amt_x;

  // status of the held operation against the current depth
  always_comb begin
    status = ST_OK;
    case (op_r)
      OP_PUSH: begin
        if (full) status = ST_OVERFLOW;
      end
      OP_POP: begin
        if (cnt_x == '0) status = ST_RANGE;
      end
      OP_PEEK, OP_REPL_AT: begin
        if (amt_ge) status = ST_RANGE;
      end
      OP_REPL_TOP: begin
        if (amt_gt) status = ST_RANGE;
        else if (amt_x == '0 && full) status = ST_OVERFLOW;
      end
      OP_REVERSE: begin
        if (amt_gt) status = ST_RANGE;
      end
      OP_SWAP: begin
        if (cnt_x < CMP_W'(2)) status = ST_RANGE;
      end
      default: status = ST_OK;
    endcase
  end

  assign stat.op          = op_r;
  assign stat.err         = (status != ST_OK);
  assign stat.rev_trivial = (rev_n <= CMP_W'(1));
  assign stat.rev_more    = (lo_r + ADDR_W'(1)) < (hi_r - ADDR_W'(1));

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      ADDR_TOP:   rd_addr = ADDR_W'(cnt_x - CMP_W'(1));
      ADDR_DEPTH: rd_addr = ADDR_W'(cnt_x - CMP_W'(1) - amt_x);
      ADDR_LO:    rd_addr = lo_r;
      ADDR_HI:    rd_addr = hi_r;
      default:    rd_addr = ADDR_W'(cnt_x - CMP_W'(1));
    endcase
  end

  // write address select
  always_comb begin
    case (cmd.wr_sel)
      ADDR_PUSH:  wr_addr = ADDR_W'(cnt_x);
      ADDR_REPL:  wr_addr = ADDR_W'(cnt_x - amt_x);
      ADDR_DEPTH: wr_addr = ADDR_W'(cnt_x - CMP_W'(1) - amt_x);
      ADDR_LO:    wr_addr = lo_r;
      ADDR_HI:    wr_addr = hi_r;
      default:    wr_addr = ADDR_W'(cnt_x);
    endcase
  end

  // write data select
  always_comb begin
    case (cmd.wdata_sel)
      WDATA_VALUE: wr_data = value_r;
      WDATA_RDATA: wr_data = rd_data;
      WDATA_TMP:   wr_data = tmp_r;
      default:     wr_data = value_r;
    endcase
  end

  // stack storage
  ose_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // entry count update, pop clamped to the depth
  always_comb begin
    case (cmd.cnt_op)
      CNT_PUSH:  count_nxt = CNT_W'(cnt_x + CMP_W'(1));
      CNT_REPL:  count_nxt = CNT_W'(cnt_x - amt_x + CMP_W'(1));
      CNT_POP:   count_nxt = CNT_W'(cnt_x - (amt_gt ? cnt_x : amt_x));
      CNT_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // reverse pair pointers and the held low word
  always_ff @(posedge clk) begin
    if (cmd.rev_init) begin
      lo_r <= ADDR_W'(cnt_x - rev_n);
      hi_r <= ADDR_W'(cnt_x - CMP_W'(1));
    end else if (cmd.rev_step) begin
      lo_r <= lo_r + ADDR_W'(1);
      hi_r <= hi_r - ADDR_W'(1);
    end
    if (cmd.tmp_load) begin
      tmp_r <= rd_data;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_value_r  <= cmd.res_rdata ? FIELD_W'(rd_data) : '0;
      res_status_r <= status;
      res_depth_r  <= DEPTH_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= cmd.res_load;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_read_value = res_value_r;
  assign out_status     = res_status_r;
  assign out_depth      = res_depth_r;

endmodule

>>> rtl/ose_ctrl.sv
// operand stack engine controller: command sequencing for each operation
// and the reverse pair walk; uses ose_pkg
module ose_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ose_pkg::ose_stat_t stat,
  output ose_pkg::ose_cmd_t  cmd
);

  import ose_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = ADDR_TOP;
    cmd.wr_sel    = ADDR_PUSH;
    cmd.wdata_sel = WDATA_VALUE;
    cmd.cnt_op    = CNT_HOLD;
    case (state_r)
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (stat.err) begin
          cmd.res_load = 1'b1;
        end else begin
          case (stat.op)
            OP_PUSH: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = ADDR_PUSH;
              cmd.cnt_op   = CNT_PUSH;
              cmd.res_load = 1'b1;
            end
            OP_POP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ADDR_TOP;
              state_nxt  = S_READ;
            end
            OP_PEEK: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ADDR_DEPTH;
              state_nxt  = S_READ;
            end
            OP_REPL_TOP: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = ADDR_REPL;
              cmd.cnt_op   = CNT_REPL;
              cmd.res_load = 1'b1;
            end
            OP_REPL_AT: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = ADDR_DEPTH;
              cmd.res_load = 1'b1;
            end
            OP_REVERSE, OP_SWAP: begin
              if (stat.rev_trivial) begin
                cmd.res_load = 1'b1;
              end else begin
                cmd.rev_init = 1'b1;
                state_nxt    = S_REV_RD_LO;
              end
            end
            default: begin
              cmd.cnt_op   = CNT_CLEAR;
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.res_load  = 1'b1;
        cmd.res_rdata = 1'b1;
        if (stat.op == OP_POP) cmd.cnt_op = CNT_POP;
        state_nxt = S_IDLE;
      end
      // pair walk: read low, read high, write low, write high
      S_REV_RD_LO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_LO;
        state_nxt  = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = ADDR_HI;
        cmd.tmp_load = 1'b1;
        state_nxt    = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = ADDR_LO;
        cmd.wdata_sel = WDATA_RDATA;
        state_nxt     = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = ADDR_HI;
        cmd.wdata_sel = WDATA_TMP;
        cmd.rev_step  = 1'b1;
        if (stat.rev_more) begin
          state_nxt = S_REV_RD_LO;
        end else begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> rtl/operand_stack_engine.sv
// operand stack engine top level: joins the controller and the datapath
// uses ose_pkg, ose_ctrl, ose_datapath and operand_stack_engine_macros.svh
//
//   channel   handshake            payload
//   command   start, busy          in_operation, in_value, in_amount
//   result    out_valid (strobe)   out_read_value, out_status, out_depth
//
// a command transfers at a rising edge with start high and busy low
// push, replace, clear and every failed operation: decode loads the result
// pop and peek: a read state follows decode, for the registered stack ram read
// reverse and swap: read low, read high, write low, write high for each pair,
// on one ram read and write port; synchronous reset empties the stack; each
// result is shown for one cycle and the receiver cannot stall it
`include "operand_stack_engine_macros.svh"

module operand_stack_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ose_pkg::OP_W-1:0]    in_operation,
  input  logic [ose_pkg::FIELD_W-1:0] in_value,
  input  logic [ose_pkg::AMT_W-1:0]   in_amount,
  output logic                        out_valid,
  output logic [ose_pkg::FIELD_W-1:0] out_read_value,
  output logic [ose_pkg::STAT_W-1:0]  out_status,
  output logic [ose_pkg::DEPTH_W-1:0] out_depth
);

  import ose_pkg::*;

  ose_cmd_t  cmd;
  ose_stat_t stat;

  // sequencing
  ose_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage and arithmetic
  ose_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_amount      (in_amount),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_depth      (out_depth)
  );

  // checks on sequencing and result encoding
  `OSE_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted command did not raise busy")
  `OSE_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held past one cycle")
  `OSE_ASSERT_IMPL(a_idle_on_result, clk, rst_n, out_valid, !busy, "result shown while still busy")
  `OSE_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status == ST_OK || out_status == ST_OVERFLOW || out_status == ST_RANGE, "undefined status code")
  `OSE_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && out_status != ST_OK, out_read_value == '0, "failed operation returned a word")

endmodule
